FILE: design/dmc_pkg.sv
// Shared types and constants for the direct-mapped cache tag control block.
package dmc_pkg;

    localparam int ADDR_W          = 48;
    localparam int SLOT_OUT_W      = 10;
    localparam int ENTRIES_DEF     = 1024;
    localparam int BLOCK_SHIFT_DEF = 12;

    typedef enum logic [1:0] {
        KIND_PROBE  = 2'd0,
        KIND_INSERT = 2'd1,
        KIND_CLEAN  = 2'd2,
        KIND_INVAL  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_LOOK  = 3'b100
    } t_state;

endpackage

FILE: design/dmc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module dmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/direct_mapped_cache_tag_control.sv
// Top level of the direct-mapped cache tag control store.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+---------------------------------------
//  request | in        | i_in_valid / o_in_stall   | i_kind, i_addr, i_dirty_in
//  result  | out       | o_out_valid / i_out_stall | o_hit, o_hit_dirty, o_victim_valid,
//          |           |                           | o_evict_addr, o_evict_dirty, o_slot
//
// Each request first reads the entry RAM, then checks the tag and writes the entry back.
// After reset a clearing pass zeroes all ENTRIES entries, one per cycle, with o_in_stall high.
// A request is taken while a result waits; the tag check then holds until the
// result register is free.
module direct_mapped_cache_tag_control #(
    parameter int ENTRIES     = dmc_pkg::ENTRIES_DEF,
    parameter int BLOCK_SHIFT = dmc_pkg::BLOCK_SHIFT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  dmc_pkg::t_kind                i_kind,
    input  logic [dmc_pkg::ADDR_W-1:0]    i_addr,
    input  logic                          i_dirty_in,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_hit,
    output logic                          o_hit_dirty,
    output logic                          o_victim_valid,
    output logic [dmc_pkg::ADDR_W-1:0]    o_evict_addr,
    output logic                          o_evict_dirty,
    output logic [dmc_pkg::SLOT_OUT_W-1:0] o_slot
);

    import dmc_pkg::*;

    localparam int SLOT_W = $clog2(ENTRIES);
    localparam int WORD_W = ADDR_W + 2;

    t_state              r_state, n_state;
    logic [SLOT_W-1:0]   r_clr;
    t_kind               r_kind;
    logic [ADDR_W-1:0]   r_addr;
    logic                r_din;
    logic [SLOT_W-1:0]   r_slot;

    logic                r_out_valid;
    logic                r_hit, r_hit_dirty, r_victim_valid, r_evict_dirty;
    logic [ADDR_W-1:0]   r_evict_addr;
    logic [SLOT_W-1:0]   r_out_slot;

    logic                in_xfer, out_free, done;
    logic                we;
    logic [SLOT_W-1:0]   waddr, raddr;
    logic [WORD_W-1:0]   wdata, rdata;
    logic                e_valid, e_dirty, same, hit, victim;
    logic [ADDR_W-1:0]   e_tag;

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign done     = (r_state == ST_LOOK) && out_free;

    // entry word: {valid, dirty, tag}
    assign e_valid = rdata[ADDR_W+1];
    assign e_dirty = rdata[ADDR_W];
    assign e_tag   = rdata[ADDR_W-1:0];
    assign same    = e_tag == r_addr;
    assign hit     = e_valid && same;
    assign victim  = e_valid && !same;

    assign raddr = (r_state == ST_IDLE) ? i_addr[BLOCK_SHIFT +: SLOT_W] : r_slot;

    always_comb begin
        we    = 1'b0;
        waddr = r_slot;
        wdata = rdata;
        if (r_state == ST_CLEAR) begin
            we    = 1'b1;
            waddr = r_clr;
            wdata = '0;
        end else if (done) begin
            case (r_kind)
                KIND_INSERT: begin
                    we    = 1'b1;
                    wdata = {1'b1, r_din, r_addr};
                end
                KIND_CLEAN: begin
                    we    = hit;
                    wdata = {1'b1, 1'b0, e_tag};
                end
                KIND_INVAL: begin
                    we    = hit;
                    wdata = {1'b0, e_dirty, e_tag};
                end
                default: begin
                    we = 1'b0;
                end
            endcase
        end
    end

    dmc_ram #(
        .WIDTH(WORD_W),
        .DEPTH(ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr == SLOT_W'(ENTRIES - 1)) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (in_xfer) n_state = ST_LOOK;
            end
            ST_LOOK: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) r_clr <= r_clr + 1'b1;
            if (done) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_kind <= i_kind;
            r_addr <= i_addr;
            r_din  <= i_dirty_in;
            r_slot <= i_addr[BLOCK_SHIFT +: SLOT_W];
        end
        if (done) begin
            r_hit          <= hit;
            r_hit_dirty    <= hit && e_dirty;
            r_victim_valid <= victim;
            r_evict_addr   <= victim ? e_tag : '0;
            r_evict_dirty  <= victim && e_dirty;
            r_out_slot     <= r_slot;
        end
    end

    assign o_in_stall     = r_state != ST_IDLE;
    assign o_out_valid    = r_out_valid;
    assign o_hit          = r_hit;
    assign o_hit_dirty    = r_hit_dirty;
    assign o_victim_valid = r_victim_valid;
    assign o_evict_addr   = r_evict_addr;
    assign o_evict_dirty  = r_evict_dirty;
    assign o_slot         = SLOT_OUT_W'(r_out_slot);

    a_load_from_look: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == ST_LOOK)
        else $error("result loaded outside tag check");

    a_hit_xor_victim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_hit && o_victim_valid))
        else $error("hit and victim both set");

    a_no_victim_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_victim_valid) |-> (o_evict_addr == '0 && !o_evict_dirty))
        else $error("victim fields set without victim");

    a_dirty_needs_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_hit_dirty) |-> o_hit)
        else $error("hit_dirty without hit");

    a_look_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOOK && r_out_valid && i_out_stall) |-> !we)
        else $error("entry written while result stalled");

endmodule

FILE: verif/tb.sv
// Self-checking testbench for the direct-mapped cache tag control block.
module tb;
    import dmc_pkg::*;

    localparam int NUM_SLOTS   = ENTRIES_DEF;
    localparam int HOT_COUNT   = 16;
    localparam int HOLD_CYCLES = 60;
    localparam int IDLE_LIMIT  = 4000;
    localparam int RAND_ITEMS  = 125;
    localparam int HOLD_ITEMS  = 40;

    typedef enum int {
        MODE_FREE,
        MODE_SEND_IDLE,
        MODE_RECV_STALL,
        MODE_BOTH,
        MODE_HOLD
    } t_mode;

    typedef struct {
        t_kind              kind;
        logic [ADDR_W-1:0]  addr;
        logic               dirty_in;
    } t_req;

    typedef struct {
        logic                  hit;
        logic                  hit_dirty;
        logic                  victim_valid;
        logic [ADDR_W-1:0]     evict_addr;
        logic                  evict_dirty;
        logic [SLOT_OUT_W-1:0] slot;
    } t_lookup;

    logic                  i_clk;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    t_kind                 i_kind = KIND_PROBE;
    logic [ADDR_W-1:0]     i_addr = '0;
    logic                  i_dirty_in = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic                  o_hit;
    logic                  o_hit_dirty;
    logic                  o_victim_valid;
    logic [ADDR_W-1:0]     o_evict_addr;
    logic                  o_evict_dirty;
    logic [SLOT_OUT_W-1:0] o_slot;

    t_req              req_q[$];
    t_lookup           lookup_q[$];
    bit [ADDR_W-1:0]   shadow_tag[NUM_SLOTS];
    bit                shadow_valid[NUM_SLOTS];
    bit                shadow_dirty[NUM_SLOTS];
    bit [ADDR_W-1:0]   hot_addr[HOT_COUNT];

    t_mode mode = MODE_FREE;
    int    send_idle_pct = 0;
    int    stall_pct = 0;
    int    hold_cnt = 0;
    int    n_pushed = 0;
    int    n_accepted = 0;
    int    idle_cycles = 0;
    int    errors = 0;
    bit    in_fire = 1'b0;

    direct_mapped_cache_tag_control i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_kind         (i_kind),
        .i_addr         (i_addr),
        .i_dirty_in     (i_dirty_in),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_hit          (o_hit),
        .o_hit_dirty    (o_hit_dirty),
        .o_victim_valid (o_victim_valid),
        .o_evict_addr   (o_evict_addr),
        .o_evict_dirty  (o_evict_dirty),
        .o_slot         (o_slot)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // Looks up the shadow entry and applies the request to it.
    task automatic lookup_and_update(input t_req r, output t_lookup res);
        int  s;
        bit  same;
        s = int'((r.addr >> BLOCK_SHIFT_DEF) & (NUM_SLOTS - 1));
        same = shadow_tag[s] == r.addr;
        res.hit          = shadow_valid[s] && same;
        res.hit_dirty    = res.hit && shadow_dirty[s];
        res.victim_valid = shadow_valid[s] && !same;
        res.evict_addr   = res.victim_valid ? shadow_tag[s] : '0;
        res.evict_dirty  = res.victim_valid && shadow_dirty[s];
        res.slot         = SLOT_OUT_W'(s);
        case (r.kind)
            KIND_INSERT: begin
                shadow_tag[s]   = r.addr;
                shadow_valid[s] = 1'b1;
                shadow_dirty[s] = r.dirty_in;
            end
            KIND_CLEAN: begin
                if (res.hit) shadow_dirty[s] = 1'b0;
            end
            KIND_INVAL: begin
                if (res.hit) shadow_valid[s] = 1'b0;
            end
            default: ;
        endcase
    endtask

    task automatic check_field(input string name, input logic [ADDR_W-1:0] want,
                               input logic [ADDR_W-1:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    task automatic push_req(input t_kind k, input logic [ADDR_W-1:0] a, input logic d);
        t_req r;
        r.kind = k;
        r.addr = a;
        r.dirty_in = d;
        req_q.push_back(r);
        n_pushed++;
    endtask

    function automatic t_req rand_request();
        t_req r;
        int   pick;
        pick = $urandom_range(99);
        if (pick < 35) r.kind = KIND_INSERT;
        else if (pick < 60) r.kind = KIND_PROBE;
        else if (pick < 80) r.kind = KIND_CLEAN;
        else r.kind = KIND_INVAL;
        if ($urandom_range(99) < 80) r.addr = hot_addr[$urandom_range(HOT_COUNT - 1)];
        else r.addr = ADDR_W'({$urandom(), $urandom()});
        r.dirty_in = 1'($urandom_range(1));
        return r;
    endfunction

    // Request driver
    always @(negedge i_clk) begin : drive_req
        t_req r;
        if (i_rst_n && (!i_in_valid || in_fire)) begin
            if (req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                r = req_q.pop_front();
                i_in_valid <= 1'b1;
                i_kind     <= r.kind;
                i_addr     <= r.addr;
                i_dirty_in <= r.dirty_in;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Result back-pressure, with one long hold-off
    always @(negedge i_clk) begin
        if (mode == MODE_HOLD && hold_cnt < HOLD_CYCLES) begin
            hold_cnt    <= hold_cnt + 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= $urandom_range(99) < stall_pct;
        end
    end

    // Monitor and scoreboard
    always @(posedge i_clk) begin : monitor
        t_lookup want;
        t_req    r;
        bit      req_xfer;
        bit      res_xfer;
        req_xfer = i_rst_n && i_in_valid && !o_in_stall;
        res_xfer = i_rst_n && o_out_valid && !i_out_stall;
        in_fire <= req_xfer;
        if (res_xfer) begin
            if (lookup_q.size() == 0) begin
                errors++;
                $display("%0t: result transfer with nothing expected, slot %h", $time, o_slot);
            end else begin
                want = lookup_q.pop_front();
                check_field("hit", ADDR_W'(want.hit), ADDR_W'(o_hit));
                check_field("hit_dirty", ADDR_W'(want.hit_dirty), ADDR_W'(o_hit_dirty));
                check_field("victim_valid", ADDR_W'(want.victim_valid),
                            ADDR_W'(o_victim_valid));
                check_field("evict_addr", want.evict_addr, o_evict_addr);
                check_field("evict_dirty", ADDR_W'(want.evict_dirty), ADDR_W'(o_evict_dirty));
                check_field("slot", ADDR_W'(want.slot), ADDR_W'(o_slot));
            end
        end
        if (req_xfer) begin
            r.kind = i_kind;
            r.addr = i_addr;
            r.dirty_in = i_dirty_in;
            lookup_and_update(r, want);
            lookup_q.push_back(want);
            n_accepted <= n_accepted + 1;
        end
        idle_cycles <= (req_xfer || res_xfer) ? 0 : idle_cycles + 1;
    end

    initial begin
        while (idle_cycles < IDLE_LIMIT) @(posedge i_clk);
        $display("Some tests failed");
        $finish;
    end

    initial begin
        int              i;
        int              m;
        bit [ADDR_W-1:0] a;
        bit [9:0]        hot_slot[4];
        localparam logic [ADDR_W-1:0] ADDR_ZERO = '0;
        localparam logic [ADDR_W-1:0] ADDR_MAX  = '1;
        localparam logic [ADDR_W-1:0] ADDR_ALT  = 48'h7FFF_FFFF_F000;
        localparam logic [ADDR_W-1:0] ADDR_ODD  = 48'h0000_0000_0FFF;

        for (i = 0; i < 4; i++) hot_slot[i] = 10'($urandom_range(NUM_SLOTS - 1));
        for (i = 0; i < HOT_COUNT; i++) begin
            a = ADDR_W'({$urandom(), $urandom()});
            a[21:12] = hot_slot[i % 4];
            if ($urandom_range(3) != 0) a[11:0] = '0;
            hot_addr[i] = a;
        end

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty slot, insert/probe/clean, unaligned conflict
        push_req(KIND_PROBE,  ADDR_ZERO, 1'b1);
        push_req(KIND_INSERT, ADDR_ZERO, 1'b1);
        push_req(KIND_PROBE,  ADDR_ZERO, 1'b0);
        push_req(KIND_CLEAN,  ADDR_ZERO, 1'b1);
        push_req(KIND_PROBE,  ADDR_ZERO, 1'b0);
        push_req(KIND_PROBE,  ADDR_ODD,  1'b0);
        push_req(KIND_INSERT, ADDR_ODD,  1'b1);
        push_req(KIND_CLEAN,  ADDR_ZERO, 1'b0);
        push_req(KIND_INVAL,  ADDR_ZERO, 1'b1);
        push_req(KIND_PROBE,  ADDR_ODD,  1'b0);
        // top slot: dirty eviction, invalidate, stale dirty bit
        push_req(KIND_INSERT, ADDR_MAX,  1'b1);
        push_req(KIND_INSERT, ADDR_ALT,  1'b0);
        push_req(KIND_INVAL,  ADDR_MAX,  1'b0);
        push_req(KIND_INVAL,  ADDR_ALT,  1'b0);
        push_req(KIND_INSERT, ADDR_MAX,  1'b1);
        push_req(KIND_INVAL,  ADDR_MAX,  1'b1);
        push_req(KIND_PROBE,  ADDR_MAX,  1'b1);
        push_req(KIND_CLEAN,  ADDR_MAX,  1'b0);
        push_req(KIND_INSERT, ADDR_ALT,  1'b0);
        push_req(KIND_PROBE,  ADDR_ALT,  1'b0);
        push_req(KIND_INSERT, ADDR_ODD,  1'b0);
        push_req(KIND_PROBE,  ADDR_ODD,  1'b1);
        while (n_accepted < n_pushed) @(posedge i_clk);

        for (m = MODE_FREE; m <= MODE_HOLD; m++) begin
            mode = t_mode'(m);
            send_idle_pct = (mode == MODE_SEND_IDLE) ? 83 : (mode == MODE_BOTH) ? 28 : 0;
            stall_pct = (mode == MODE_RECV_STALL) ? 83 : (mode == MODE_BOTH) ? 28 : 0;
            for (i = 0; i < ((mode == MODE_HOLD) ? HOLD_ITEMS : RAND_ITEMS); i++) begin
                req_q.push_back(rand_request());
                n_pushed++;
            end
            while (n_accepted < n_pushed) @(posedge i_clk);
        end

        while (lookup_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (errors == 0 && lookup_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
